### hdl/ffca_pkg.sv
package ffca_pkg;

    localparam int FFCA_CELLS       = 128;
    localparam int FFCA_HANDLE_BITS = 16;

    localparam int CMD_W    = 2;
    localparam int AMOUNT_W = 8;
    localparam int ACTIVE_W = 8;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 8'd100;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPACT = 2'd2;

    typedef enum logic [1:0] {
        ST_GIVEN   = 2'd0,
        ST_NULL    = 2'd1,
        ST_ILLEGAL = 2'd2,
        ST_SILENT  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_ZERO,
        S_DONE
    } fsm_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_START,
        OP_SCAN,
        OP_FILL,
        OP_ZERO,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        logic             clear_last;
        logic             pre_null;
        logic             found;
        logic             scan_done;
        logic             fill_last;
        logic             zero_done;
        logic [CMD_W-1:0] cmd;
    } dp_stat_t;

endpackage

### hdl/ffca_if.sv
interface ffca_req_if
    import ffca_pkg::*;
#(
    parameter int HANDLE_BITS = FFCA_HANDLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [AMOUNT_W-1:0]    amount;
    logic [HANDLE_BITS-1:0] handle;

    modport source (output valid, command, amount, handle, input ready);
    modport sink   (input valid, command, amount, handle, output ready);
endinterface

interface ffca_rsp_if
    import ffca_pkg::*;
#(
    parameter int HANDLE_BITS = FFCA_HANDLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] handle_out;

    modport source (output valid, status, handle_out, input ready);
    modport sink   (input valid, status, handle_out, output ready);
endinterface

interface ffca_cfg_if
    import ffca_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTIVE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hdl/ffca_ctrl.sv
module ffca_ctrl
    import ffca_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_stat_t stat,
    output dp_op_t   op
);

    fsm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       push;
    logic       skip_scan;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign skip_scan = (stat.cmd != CMD_ALLOC && stat.cmd != CMD_ERASE
                        && stat.cmd != CMD_COMPACT)
                       || (stat.cmd == CMD_ALLOC && stat.pre_null);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                priority if (skip_scan)
                    state_next = S_DONE;
                else if (stat.found)
                    state_next = S_FILL;
                else if (stat.scan_done)
                    state_next = (stat.cmd == CMD_COMPACT) ? S_ZERO : S_DONE;
            end
            S_FILL:
            begin
                if (stat.fill_last)
                    state_next = S_DONE;
            end
            S_ZERO:
            begin
                if (stat.zero_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op        = OP_NONE;
        req_ready = 1'b0;
        push      = 1'b0;
        unique case (state_reg)
            S_CLEAR: op = OP_CLEAR;
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                    op = OP_START;
            end
            S_SCAN:
            begin
                if (!skip_scan)
                    op = OP_SCAN;
            end
            S_FILL: op = OP_FILL;
            S_ZERO: op = OP_ZERO;
            S_DONE:
            begin
                if (out_free)
                begin
                    op   = OP_PUSH;
                    push = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (push)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/ffca_dp.sv
module ffca_dp
    import ffca_pkg::*;
#(
    parameter int CELLS       = FFCA_CELLS,
    parameter int HANDLE_BITS = FFCA_HANDLE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_op_t                 op,
    input  logic                   cfg_we,
    input  logic [ACTIVE_W-1:0]    cfg_data,
    input  logic [CMD_W-1:0]       command,
    input  logic [AMOUNT_W-1:0]    amount,
    input  logic [HANDLE_BITS-1:0] handle,
    output dp_stat_t               stat,
    output status_t                status,
    output logic [HANDLE_BITS-1:0] handle_out
);

    localparam int IDX_W = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int CW    = (CNT_W > AMOUNT_W) ? CNT_W : AMOUNT_W;
    localparam int SW    = CW + 1;

    logic [HANDLE_BITS-1:0] mem [CELLS];
    logic [HANDLE_BITS-1:0] q_reg;

    logic [CNT_W-1:0]       ptr_reg, ptr_next;
    logic                   pipe_v_reg, pipe_v_next;
    logic [IDX_W-1:0]       pipe_idx_reg, pipe_idx_next;
    logic [AMOUNT_W-1:0]    run_reg, run_next;
    logic [CNT_W-1:0]       wr_reg, wr_next;
    logic [IDX_W-1:0]       end_idx_reg, end_idx_next;
    logic [HANDLE_BITS-1:0] last_handle_reg, last_handle_next;
    logic                   given_reg, given_next;
    logic                   hit_reg, hit_next;
    logic [ACTIVE_W-1:0]    active_reg, active_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [AMOUNT_W-1:0]    amount_reg, amount_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    status_t                out_status_reg, out_status_next;
    logic [HANDLE_BITS-1:0] out_handle_reg, out_handle_next;

    logic [CNT_W-1:0]       lim;
    logic                   issue;
    logic [AMOUNT_W:0]      run_calc;
    logic                   hit_now;
    logic                   found_now;
    logic [SW-1:0]          start_w;
    logic                   we;
    logic [IDX_W-1:0]       wa;
    logic [HANDLE_BITS-1:0] wd;
    status_t                res_status;

    // an active count above the store size acts as the store size
    always_comb
    begin
        if (CW'(active_reg) > CW'(CELLS))
            lim = CNT_W'(CELLS);
        else
            lim = CNT_W'(active_reg);
    end

    assign issue     = ptr_reg < lim;
    assign run_calc  = (q_reg == '0) ? ({1'b0, run_reg} + (AMOUNT_W+1)'(1)) : '0;
    assign hit_now   = pipe_v_reg && (handle_reg != '0) && (q_reg == handle_reg);
    assign found_now = pipe_v_reg && (cmd_reg == CMD_ALLOC)
                       && (run_calc == {1'b0, amount_reg});
    assign start_w   = SW'(pipe_idx_reg) + SW'(1) - SW'(amount_reg);

    assign stat.clear_last = ptr_reg == CNT_W'(CELLS - 1);
    assign stat.pre_null   = (amount_reg == '0) || (CW'(amount_reg) > CW'(lim))
                             || (last_handle_reg == '1);
    assign stat.found      = found_now;
    assign stat.scan_done  = !issue && !pipe_v_reg;
    assign stat.fill_last  = ptr_reg[IDX_W-1:0] == end_idx_reg;
    assign stat.zero_done  = !(wr_reg < lim);
    assign stat.cmd        = cmd_reg;

    always_comb
    begin
        unique case (cmd_reg)
            CMD_ALLOC:   res_status = given_reg ? ST_GIVEN : ST_NULL;
            CMD_ERASE:   res_status = hit_reg ? ST_SILENT : ST_ILLEGAL;
            default:     res_status = ST_SILENT;
        endcase
    end

    always_comb
    begin
        ptr_next         = ptr_reg;
        pipe_v_next      = pipe_v_reg;
        pipe_idx_next    = pipe_idx_reg;
        run_next         = run_reg;
        wr_next          = wr_reg;
        end_idx_next     = end_idx_reg;
        last_handle_next = last_handle_reg;
        given_next       = given_reg;
        hit_next         = hit_reg;
        cmd_next         = cmd_reg;
        amount_next      = amount_reg;
        handle_next      = handle_reg;
        out_status_next  = out_status_reg;
        out_handle_next  = out_handle_reg;
        active_next      = cfg_we ? cfg_data : active_reg;
        we               = 1'b0;
        wa               = ptr_reg[IDX_W-1:0];
        wd               = '0;

        unique case (op)
            OP_NONE:
            begin
            end
            OP_CLEAR:
            begin
                we       = 1'b1;
                ptr_next = ptr_reg + CNT_W'(1);
            end
            OP_START:
            begin
                cmd_next    = command;
                amount_next = amount;
                handle_next = handle;
                ptr_next    = '0;
                pipe_v_next = 1'b0;
                run_next    = '0;
                wr_next     = '0;
                given_next  = 1'b0;
                hit_next    = 1'b0;
            end
            OP_SCAN:
            begin
                // read one cell ahead, evaluate the cell read last cycle
                pipe_v_next   = issue;
                pipe_idx_next = ptr_reg[IDX_W-1:0];
                if (issue)
                    ptr_next = ptr_reg + CNT_W'(1);
                if (pipe_v_reg)
                    run_next = run_calc[AMOUNT_W-1:0];
                unique case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (found_now)
                        begin
                            ptr_next         = CNT_W'(start_w);
                            end_idx_next     = pipe_idx_reg;
                            given_next       = 1'b1;
                            last_handle_next = last_handle_reg + HANDLE_BITS'(1);
                        end
                    end
                    CMD_ERASE:
                    begin
                        if (hit_now)
                        begin
                            we       = 1'b1;
                            wa       = pipe_idx_reg;
                            hit_next = 1'b1;
                        end
                    end
                    CMD_COMPACT:
                    begin
                        if (pipe_v_reg && (q_reg != '0))
                        begin
                            we      = 1'b1;
                            wa      = wr_reg[IDX_W-1:0];
                            wd      = q_reg;
                            wr_next = wr_reg + CNT_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_FILL:
            begin
                we       = 1'b1;
                wd       = last_handle_reg;
                ptr_next = ptr_reg + CNT_W'(1);
            end
            OP_ZERO:
            begin
                if (wr_reg < lim)
                begin
                    we      = 1'b1;
                    wa      = wr_reg[IDX_W-1:0];
                    wr_next = wr_reg + CNT_W'(1);
                end
            end
            OP_PUSH:
            begin
                out_status_next = res_status;
                out_handle_next = (res_status == ST_GIVEN) ? last_handle_reg : '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        q_reg <= mem[ptr_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg         <= '0;
            pipe_v_reg      <= 1'b0;
            last_handle_reg <= '0;
            active_reg      <= ACTIVE_RESET;
        end
        else
        begin
            ptr_reg         <= ptr_next;
            pipe_v_reg      <= pipe_v_next;
            last_handle_reg <= last_handle_next;
            active_reg      <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg   <= pipe_idx_next;
        run_reg        <= run_next;
        wr_reg         <= wr_next;
        end_idx_reg    <= end_idx_next;
        given_reg      <= given_next;
        hit_reg        <= hit_next;
        cmd_reg        <= cmd_next;
        amount_reg     <= amount_next;
        handle_reg     <= handle_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
    end

    assign status     = out_status_reg;
    assign handle_out = out_handle_reg;

endmodule

### hdl/first_fit_cell_allocator_top.sv
// First-fit cell allocator. Requests are handled one at a time through a
// single-port-write, registered-read owner store: alloc makes one scan and,
// when a run is found, then the fill; erase makes one scan; defragment makes
// a scan with in-place copy, then zeroing of the tail. An unknown command and
// an alloc that is null from the outset skip the scan. A finished response
// sits in an output register, so the next request is taken while it waits.
// After reset the store is cleared one cell per cycle with req.ready low;
// configuration writes are taken at any time and take effect at once, so
// make them only while no request is in flight.
module first_fit_cell_allocator_top
    import ffca_pkg::*;
#(
    parameter int CELLS       = FFCA_CELLS,
    parameter int HANDLE_BITS = FFCA_HANDLE_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    ffca_req_if.sink   req,
    ffca_rsp_if.source rsp,
    ffca_cfg_if.sink   cfg
);

    dp_op_t   op;
    dp_stat_t stat;
    status_t  status;

    assign cfg.ready = 1'b1;

    ffca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .op        (op)
    );

    ffca_dp #(
        .CELLS       (CELLS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .cfg_we     (cfg.valid),
        .cfg_data   (cfg.data),
        .command    (req.command),
        .amount     (req.amount),
        .handle     (req.handle),
        .stat       (stat),
        .status     (status),
        .handle_out (rsp.handle_out)
    );

    assign rsp.status = status;

endmodule

### hdl/ffca_checker.sv
module ffca_checker
    import ffca_pkg::*;
#(
    parameter int HANDLE_BITS = FFCA_HANDLE_BITS
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic [1:0]             status,
    input logic [HANDLE_BITS-1:0] handle_out
);

    logic [HANDLE_BITS-1:0] last_given_reg, last_given_next;

    always_comb
    begin
        last_given_next = last_given_reg;
        if (rsp_valid && rsp_ready && status == ST_GIVEN)
            last_given_next = handle_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_given_reg <= '0;
        else
            last_given_reg <= last_given_next;
    end

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(handle_out))
        else $error("response changed while stalled");

    // one request at a time
    a_req_single: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in progress");

    a_handle_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((status == ST_GIVEN) == (handle_out != '0)))
        else $error("handle_out does not match status");

    a_handle_rises: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_GIVEN |-> handle_out > last_given_reg)
        else $error("issued handle did not advance");

endmodule

bind first_fit_cell_allocator_top ffca_checker #(
    .HANDLE_BITS (HANDLE_BITS)
) u_ffca_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (rsp.status),
    .handle_out (rsp.handle_out)
);

### tb/sv/tb_first_fit_cell_allocator_top.sv
module tb_first_fit_cell_allocator_top;
    import ffca_pkg::*;

    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 215;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [FFCA_HANDLE_BITS-1:0] HANDLE_TOP = '1;

    typedef logic [FFCA_HANDLE_BITS-1:0] handle_t;

    typedef struct packed {
        status_t status;
        handle_t handle;
    } alloc_reply_t;

    class alloc_ledger;
        handle_t             owner [FFCA_CELLS];
        handle_t             last_handle;
        logic [ACTIVE_W-1:0] active;
        alloc_reply_t        owed_replies [$];
        int unsigned         requests;
        int unsigned         replies;
        int unsigned         mismatches;

        function new();
            foreach (owner[i])
                owner[i] = '0;
            last_handle = '0;
            active      = ACTIVE_RESET;
            requests    = 0;
            replies     = 0;
            mismatches  = 0;
        endfunction

        function void set_active(logic [ACTIVE_W-1:0] value);
            active = value;
        endfunction

        function int unsigned live_cells();
            return (active > FFCA_CELLS) ? FFCA_CELLS : active;
        endfunction

        function alloc_reply_t try_alloc(logic [AMOUNT_W-1:0] amount);
            alloc_reply_t r;
            int unsigned  lim;
            int unsigned  run;
            int unsigned  start;
            int unsigned  i;
            bit           found;
            r.status = ST_NULL;
            r.handle = '0;
            lim      = live_cells();
            run      = 0;
            start    = 0;
            found    = 1'b0;
            if (amount == 0 || amount > lim || last_handle == HANDLE_TOP)
                return r;
            for (i = 0; i < lim && !found; i++)
            begin
                run = (owner[i] == '0) ? run + 1 : 0;
                if (run == amount)
                begin
                    start = i + 1 - amount;
                    found = 1'b1;
                end
            end
            if (!found)
                return r;
            last_handle = last_handle + 1'b1;
            for (i = start; i < start + amount; i++)
                owner[i] = last_handle;
            r.status = ST_GIVEN;
            r.handle = last_handle;
            return r;
        endfunction

        function bit free_handle(handle_t h);
            int unsigned i;
            bit          hit;
            hit = 1'b0;
            if (h == '0)
                return 1'b0;
            for (i = 0; i < live_cells(); i++)
            begin
                if (owner[i] == h)
                begin
                    owner[i] = '0;
                    hit      = 1'b1;
                end
            end
            return hit;
        endfunction

        function void compact();
            int unsigned lim;
            int unsigned rd;
            int unsigned wr;
            lim = live_cells();
            wr  = 0;
            for (rd = 0; rd < lim; rd++)
            begin
                if (owner[rd] != '0)
                begin
                    owner[wr] = owner[rd];
                    wr++;
                end
            end
            for (; wr < lim; wr++)
                owner[wr] = '0;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [AMOUNT_W-1:0] amount,
                                   handle_t h);
            alloc_reply_t r;
            r.status = ST_SILENT;
            r.handle = '0;
            case (cmd)
                CMD_ALLOC:   r = try_alloc(amount);
                CMD_ERASE:   r.status = free_handle(h) ? ST_SILENT : ST_ILLEGAL;
                CMD_COMPACT: compact();
                default:     ;
            endcase
            owed_replies.push_back(r);
            requests++;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_response(logic [1:0] status, handle_t handle_out);
            alloc_reply_t want;
            replies++;
            if (owed_replies.size() == 0)
            begin
                flag($sformatf("reply %0d arrived with nothing outstanding: status %0d handle %0d",
                               replies, status, handle_out));
                return;
            end
            want = owed_replies.pop_front();
            if (status !== want.status)
                flag($sformatf("reply %0d status: expected %0d, got %0d",
                               replies, want.status, status));
            if (handle_out !== want.handle)
                flag($sformatf("reply %0d handle_out: expected %0d, got %0d",
                               replies, want.handle, handle_out));
        endfunction

        // Sample a few cells, beyond the active region too; zero if all were free.
        function handle_t owned_handle();
            handle_t h;
            int      i;
            h = '0;
            for (i = 0; i < 8 && h == '0; i++)
                h = owner[$urandom_range(0, FFCA_CELLS - 1)];
            return h;
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ffca_req_if req_bus ();
    ffca_rsp_if rsp_bus ();
    ffca_cfg_if cfg_bus ();

    first_fit_cell_allocator_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    alloc_ledger ledger;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          hold_left   = 0;
    int          cfg_writes  = 0;
    bit          idle_tx     = 1'b0;
    bit          stall_rsp   = 1'b0;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
                ledger.check_response(rsp_bus.status, rsp_bus.handle_out);
            if (req_bus.valid && req_bus.ready)
                ledger.note_request(req_bus.command, req_bus.amount, req_bus.handle);
            if (cfg_bus.valid && cfg_bus.ready)
                ledger.set_active(cfg_bus.data);
        end
    end

    // Hold each ready level for a few cycles before picking the next.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else
        begin
            rsp_bus.ready <= !stall_rsp || ($urandom_range(0, 2) != 0);
            hold_left     <= $urandom_range(0, 4);
        end
    end

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("tb_first_fit_cell_allocator_top: FAIL");
        $finish;
    end

    task automatic push_request(input logic [CMD_W-1:0] cmd, input logic [AMOUNT_W-1:0] amt,
                                input handle_t h);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (idle_tx)
                gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.command <= cmd;
        req_bus.amount  <= amt;
        req_bus.handle  <= h;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (ledger.owed_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_active(input logic [ACTIVE_W-1:0] value);
        cfg_bus.data  <= value;
        cfg_bus.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic random_request();
        int unsigned         pick;
        int unsigned         lim;
        logic [AMOUNT_W-1:0] amt;
        handle_t             h;
        lim  = ledger.live_cells();
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            if (lim == 0)
                amt = AMOUNT_W'($urandom_range(0, 3));
            else if ($urandom_range(0, 3) == 0)
                amt = AMOUNT_W'($urandom_range(1, lim));
            else
                amt = AMOUNT_W'($urandom_range(1, (lim + 5) / 6));
            push_request(CMD_ALLOC, amt, handle_t'($urandom_range(0, 65535)));
        end
        else if (pick < 75)
        begin
            h = ledger.owned_handle();
            if (h == '0)
                h = handle_t'($urandom_range(0, 65535));
            push_request(CMD_ERASE, AMOUNT_W'($urandom_range(0, 255)), h);
        end
        else if (pick < 85)
            push_request(CMD_COMPACT, AMOUNT_W'($urandom_range(0, 255)),
                         handle_t'($urandom_range(0, 65535)));
        else
            push_request(CMD_W'($urandom_range(0, 3)), AMOUNT_W'($urandom_range(0, 255)),
                         handle_t'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        logic [ACTIVE_W-1:0] phase_active [PHASES];

        ledger          = new();
        req_bus.valid   = 1'b0;
        req_bus.command = CMD_ALLOC;
        req_bus.amount  = '0;
        req_bus.handle  = '0;
        rsp_bus.ready   = 1'b0;
        cfg_bus.valid   = 1'b0;
        cfg_bus.data    = ACTIVE_RESET;
        phase_active    = '{8'd128, 8'd1, 8'd0, 8'd255, 8'd2, 8'd129, 8'd37, 8'd0};
        phase_active[PHASES-1] = ACTIVE_W'($urandom_range(1, 128));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass on the reset setting of 100 active cells.
        idle_tx   = 1'b1;
        stall_rsp = 1'b1;
        push_request(CMD_ERASE, 8'd0, 16'd0);
        push_request(CMD_ERASE, 8'd0, HANDLE_TOP);
        push_request(CMD_COMPACT, 8'd0, 16'd0);
        push_request(CMD_UNKNOWN, 8'd255, HANDLE_TOP);
        push_request(CMD_ALLOC, 8'd0, 16'd0);
        push_request(CMD_ALLOC, 8'd101, 16'd0);
        push_request(CMD_ALLOC, 8'd255, 16'd0);
        push_request(CMD_ALLOC, 8'd100, 16'd0);
        push_request(CMD_ALLOC, 8'd1, 16'd0);
        push_request(CMD_ERASE, 8'd0, 16'd1);
        push_request(CMD_ALLOC, 8'd3, 16'd0);
        push_request(CMD_ALLOC, 8'd5, 16'd0);
        push_request(CMD_ALLOC, 8'd2, 16'd0);
        push_request(CMD_ERASE, 8'd0, 16'd3);
        push_request(CMD_ALLOC, 8'd6, 16'd0);
        push_request(CMD_ALLOC, 8'd4, 16'd0);
        push_request(CMD_ERASE, 8'd0, 16'd6);
        push_request(CMD_ERASE, 8'd0, 16'd6);
        push_request(CMD_COMPACT, 8'd0, 16'd0);
        push_request(CMD_ALLOC, 8'd128, 16'd0);
        push_request(CMD_ALLOC, 8'd84, 16'd0);
        push_request(CMD_ALLOC, 8'd6, 16'd0);
        push_request(CMD_ALLOC, 8'd5, 16'd0);
        push_request(CMD_ERASE, 8'd0, 16'd2);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_active(phase_active[p]);
            idle_tx   = (p % 3 != 2);
            stall_rsp = (p % 4 != 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_request();
        end

        wait_idle();
        write_active(ACTIVE_RESET);
        idle_tx   = 1'b1;
        stall_rsp = 1'b1;
        push_request(CMD_ALLOC, 8'd1, 16'd0);
        push_request(CMD_ALLOC, 8'd0, 16'd0);
        push_request(CMD_ERASE, 8'd0, ledger.owned_handle());
        push_request(CMD_COMPACT, 8'd0, 16'd0);
        push_request(CMD_ERASE, 8'd0, HANDLE_TOP);

        wait_idle();
        repeat (24) @(posedge clk);

        $display("covered %0d requests across %0d active-cell settings, handle counter at %0d",
                 ledger.requests, cfg_writes + 1, ledger.last_handle);
        $display("checked %0d replies, %0d mismatches", ledger.replies, ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.owed_replies.size() == 0)
            $display("tb_first_fit_cell_allocator_top: PASS");
        else
            $display("tb_first_fit_cell_allocator_top: FAIL");
        $finish;
    end

endmodule

### files.f
hdl/ffca_pkg.sv
hdl/ffca_if.sv
hdl/ffca_ctrl.sv
hdl/ffca_dp.sv
hdl/first_fit_cell_allocator_top.sv
hdl/ffca_checker.sv
tb/sv/tb_first_fit_cell_allocator_top.sv
